// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, held off while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// File: rtl/epfg_pkg.sv
//----------------------------------------------------------------------------
// ESC PWM frame generator package
// Widths, reset values, register indexes and types of the frame generator.
//----------------------------------------------------------------------------
`default_nettype none

package epfg_pkg;

    localparam int NUM_MOTORS = 4;
    localparam int TIME_BITS  = 16;

    localparam int IN_MOTORS    = 4;
    localparam int WIDTH_BITS   = 16;
    localparam int THR_BITS     = 11;
    localparam int YAW_BITS     = 11;
    localparam int LEVEL_BITS   = 10;
    localparam int PERIOD_BITS  = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DAT_BITS = 16;
    localparam int CMP_BITS     = (TIME_BITS > WIDTH_BITS) ? TIME_BITS : WIDTH_BITS;

    localparam int S_DATA_BITS = 88;
    localparam int M_DATA_BITS = 8;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RST  = 16'd2008;
    localparam logic [THR_BITS-1:0]    THR_MAX_RST = 11'd1020;
    localparam logic [LEVEL_BITS-1:0]  YAW_LVL_RST = 10'd980;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_PERIOD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ARM_THR_MAX  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ARM_YAW_LVL  = 2'd2;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    typedef logic [NUM_MOTORS-1:0]                 pins_t;
    typedef logic [NUM_MOTORS-1:0][WIDTH_BITS-1:0] widths_t;
    typedef logic [TIME_BITS-1:0]                  time_t;

    typedef struct packed {
        logic [THR_BITS-1:0]        thr;
        logic signed [YAW_BITS-1:0] yaw;
        logic                       on;
    } sticks_t;

endpackage

`default_nettype wire

// File: rtl/esc_pwm_frame_generator_with_arming.sv
//----------------------------------------------------------------------------
// ESC PWM frame generator with arming
// Multichannel ESC pulse generator driven by microsecond ticks and commands.
//----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one transaction per item. s_tuser selects a one
//   microsecond tick (0) or a command (1); s_tdata carries throttle, yaw, the
//   on switch and four pulse widths. Master channel m_*: one transaction per
//   input item with the pin levels, the armed flag and the frame start flag
//   after that item.
//   The registered result appears in the cycle after the input transaction.
//   Throughput: one item per cycle unless stalled; the state update for an
//   item is a single pass of compares and a saturating increment between the
//   state registers. The result register frees in the cycle the receiver takes
//   it, so a new item is taken in the same cycle a waiting result leaves.
//   Stall: while m_tready is low and a result waits, s_tready is low and the
//   result holds.
//   Reset: disarmed, pins low, elapsed time zero, registers at their
//   defaults, no result pending.
//   Configuration: cfg_we/cfg_idx/cfg_wdata write one register per cycle;
//   write only while no item is in flight.
//----------------------------------------------------------------------------
`default_nettype none

module esc_pwm_frame_generator_with_arming
    import epfg_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  wire logic [CFG_DAT_BITS-1:0] cfg_wdata,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // throttle[10:0], yaw[21:11], on_switch[22], width_motor0[38:23],
    // width_motor1[54:39], width_motor2[70:55], width_motor3[86:71], zero[87]
    input  wire logic [S_DATA_BITS-1:0]  s_tdata,
    // op[0]
    input  wire logic                    s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // motor_pins[3:0], is_armed[4], frame_started[5], zero[7:6]
    output logic [M_DATA_BITS-1:0]       m_tdata
);

    localparam time_t TIME_MAX = {TIME_BITS{1'b1}};
    localparam pins_t PIN_MASK = {NUM_MOTORS{1'b1}};

    logic [PERIOD_BITS-1:0] period_reg;
    logic [THR_BITS-1:0]    thr_max_reg;
    logic [LEVEL_BITS-1:0]  yaw_lvl_reg;

    logic    armed_reg, armed_next;
    time_t   elapsed_reg, elapsed_next;
    pins_t   pins_reg, pins_next;
    widths_t frame_w_reg, frame_w_next;
    widths_t pend_w_reg, pend_w_next;
    sticks_t frame_st_reg, frame_st_next;
    sticks_t pend_st_reg, pend_st_next;

    logic                   m_valid_reg;
    logic [M_DATA_BITS-1:0] m_data_reg, m_data_next;

    logic    accept;
    logic    is_tick;
    time_t   elapsed_inc;
    pins_t   pins_a, pins_b;
    logic    armed_a;
    logic    start;
    widths_t in_w, src_w;
    sticks_t in_st, src_st;
    logic [IN_MOTORS-1:0][WIDTH_BITS-1:0] in_raw;
    logic [3:0] pins_out;

    function automatic pins_t fall(pins_t p, time_t el, widths_t w);
        pins_t r;
        r = p;
        for (int i = 0; i < NUM_MOTORS; i++) begin
            if (p[i] && (CMP_BITS'(el) >= CMP_BITS'(w[i])))
            begin
                r[i] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic disarm_ok(sticks_t s, logic [THR_BITS-1:0] tmax,
                                       logic [LEVEL_BITS-1:0] lvl);
        return (s.thr < tmax) && ($signed({s.yaw[YAW_BITS-1], s.yaw}) >
               $signed({2'b00, lvl})) && !s.on;
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign is_tick  = (s_tuser == OP_TICK);

    always_comb
    begin
        in_st.thr = s_tdata[10:0];
        in_st.yaw = s_tdata[21:11];
        in_st.on  = s_tdata[22];
        in_raw[0] = s_tdata[38:23];
        in_raw[1] = s_tdata[54:39];
        in_raw[2] = s_tdata[70:55];
        in_raw[3] = s_tdata[86:71];
        for (int i = 0; i < NUM_MOTORS; i++) begin
            if (i < IN_MOTORS)
            begin
                in_w[i] = in_raw[i % IN_MOTORS];
            end
            else
            begin
                in_w[i] = '0;
            end
        end
    end

    assign src_w  = is_tick ? pend_w_reg : in_w;
    assign src_st = is_tick ? pend_st_reg : in_st;
    assign elapsed_inc = (elapsed_reg == TIME_MAX) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        armed_next    = armed_reg;
        elapsed_next  = elapsed_reg;
        pins_next     = pins_reg;
        frame_w_next  = frame_w_reg;
        frame_st_next = frame_st_reg;
        pend_w_next   = pend_w_reg;
        pend_st_next  = pend_st_reg;
        pins_a        = pins_reg;
        armed_a       = armed_reg;
        start         = 1'b0;
        pins_b        = '0;

        if (is_tick)
        begin
            elapsed_next = elapsed_inc;
            if (armed_reg)
            begin
                pins_a = fall(pins_reg, elapsed_inc, frame_w_reg);
                if ((pins_reg != '0) && (pins_a == '0) &&
                    disarm_ok(frame_st_reg, thr_max_reg, yaw_lvl_reg))
                begin
                    armed_a = 1'b0;
                end
                start = armed_a && (pins_a == '0) &&
                        (CMP_BITS'(elapsed_inc) >= CMP_BITS'(period_reg));
            end
        end
        else
        begin
            pend_w_next  = in_w;
            pend_st_next = in_st;
            if (!armed_reg && (in_st.thr < thr_max_reg) && in_st.on &&
                ($signed({in_st.yaw[YAW_BITS-1], in_st.yaw}) <
                 -$signed({2'b00, yaw_lvl_reg})))
            begin
                armed_a = 1'b1;
                start   = 1'b1;
            end
        end

        armed_next = armed_a;
        pins_next  = pins_a;
        if (start)
        begin
            pins_b        = fall(PIN_MASK, '0, src_w);
            pins_next     = pins_b;
            elapsed_next  = '0;
            frame_w_next  = src_w;
            frame_st_next = src_st;
            if ((pins_b == '0) && disarm_ok(src_st, thr_max_reg, yaw_lvl_reg))
            begin
                armed_next = 1'b0;
            end
        end

        for (int i = 0; i < 4; i++) begin
            pins_out[i] = (i < NUM_MOTORS) ? pins_next[i % NUM_MOTORS] : 1'b0;
        end
        m_data_next = {2'b00, start, armed_next, pins_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= PERIOD_RST;
            thr_max_reg <= THR_MAX_RST;
            yaw_lvl_reg <= YAW_LVL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_FRAME_PERIOD: period_reg  <= cfg_wdata;
                CFG_ARM_THR_MAX:  thr_max_reg <= cfg_wdata[THR_BITS-1:0];
                CFG_ARM_YAW_LVL:  yaw_lvl_reg <= cfg_wdata[LEVEL_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            elapsed_reg <= '0;
            pins_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                armed_reg   <= armed_next;
                elapsed_reg <= elapsed_next;
                pins_reg    <= pins_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_w_reg  <= frame_w_next;
            frame_st_reg <= frame_st_next;
            pend_w_reg   <= pend_w_next;
            pend_st_reg  <= pend_st_next;
            m_data_reg   <= m_data_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/epfg_checker.sv
//----------------------------------------------------------------------------
// ESC PWM frame generator checker
// Port-level assertions on the frame generator, bound to the top level.
//----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module epfg_checker
    import epfg_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [M_DATA_BITS-1:0] m_tdata
);

    `ASSERT_IMPLIES(a_pins_need_armed, clk, rst_n, m_tvalid && (m_tdata[3:0] != 4'd0), m_tdata[4], "pin high while disarmed")
    `ASSERT_IMPLIES(a_stall_blocks_input, clk, rst_n, !s_tready, m_tvalid, "input blocked with no result waiting")
    `ASSERT_CLK(a_accept_gives_result, clk, rst_n, (s_tvalid && s_tready) |=> m_tvalid, "accepted item gave no result")
    `ASSERT_CLK(a_stall_holds, clk, rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

endmodule

bind esc_pwm_frame_generator_with_arming epfg_checker u_epfg_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
